// ----- rtl/bdlp_pkg.sv -----
package bdlp_pkg;

   // command queue between the front and the engine
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam int CFG_W     = 16;
   localparam int TIME_W    = 32;
   localparam int LEVELS_W  = 8;
   localparam int BTN_IDX_W = 3;
   localparam int QCOUNT_W  = 4;

   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_SHORT  = 2'd0,
      KIND_LONG   = 2'd1,
      KIND_REPEAT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE_TIME   = 2'd0,
      CSR_LONG_PRESS_TIME = 2'd1,
      CSR_REPEAT_INTERVAL = 2'd2
   } csr_index_type;

   typedef struct packed {
      op_type              op;
      logic [LEVELS_W-1:0] levels;
   } cmd_type;

   typedef struct packed {
      kind_type             kind;
      logic [BTN_IDX_W-1:0] button;
      logic [TIME_W-1:0]    stamp;
   } event_type;

   typedef struct packed {
      logic      valid;
      event_type ev;
   } push_type;

   typedef struct packed {
      logic                empty;
      logic [QCOUNT_W-1:0] count;
   } evq_status_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_time;
      logic [CFG_W-1:0] long_press_time;
      logic [CFG_W-1:0] repeat_interval;
   } cfg_type;

endpackage

// ----- rtl/bdlp_front.sv -----
module bdlp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic [7:0]                req_levels,
   output logic                      cmd_valid,
   output bdlp_pkg::cmd_type         cmd,
   input  logic                      cmd_take
);
   import bdlp_pkg::*;

   cmd_type                entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0]  count_ff;
   logic [CMDQ_CNT_W-1:0]  count_in;
   logic                   do_push;
   logic                   do_pop;
   cmd_type                new_cmd;

   assign req_stall = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign do_push   = req_valid && !req_stall;
   assign do_pop    = cmd_take && cmd_valid;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.op     = op_type'(req_operation);
      new_cmd.levels = req_levels;
      count_in = count_ff + CMDQ_CNT_W'(do_push) - CMDQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMDQ_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/bdlp_evq.sv -----
module bdlp_evq #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bdlp_pkg::push_type         push,
   input  logic                       pop,
   output bdlp_pkg::event_type        rd_data,
   output bdlp_pkg::evq_status_type   status
);
   import bdlp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

   event_type            mem_ff [QUEUE_DEPTH];
   event_type            rd_data_ff;
   logic [PTR_W-1:0]     write_slot_ff;
   logic [PTR_W-1:0]     read_slot_ff;
   logic [PTR_W-1:0]     used_ff;
   logic [PTR_W-1:0]     used_in;
   logic [PTR_W+3:0]     used_wide;
   logic                 full;
   logic                 empty;
   logic                 do_push;
   logic                 do_pop;

   // one slot stays free so that full and empty differ
   assign full      = (used_ff == LAST);
   assign empty     = (used_ff == '0);
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && !empty;
   assign used_in   = used_ff + PTR_W'(do_push) - PTR_W'(do_pop);
   assign used_wide = {4'b0000, used_ff};

   assign status.empty = empty;
   assign status.count = used_wide[QCOUNT_W-1:0];
   assign rd_data      = rd_data_ff;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[write_slot_ff] <= push.ev;
      end
      if (do_pop) begin
         rd_data_ff <= mem_ff[read_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         used_ff       <= '0;
      end else begin
         if (do_push) begin
            write_slot_ff <= (write_slot_ff == LAST) ? '0 : write_slot_ff + PTR_W'(1);
         end
         if (do_pop) begin
            read_slot_ff <= (read_slot_ff == LAST) ? '0 : read_slot_ff + PTR_W'(1);
         end
         used_ff <= used_in;
      end
   end

endmodule

// ----- rtl/bdlp_engine.sv -----
module bdlp_engine #(
   parameter int BUTTON_COUNT = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bdlp_pkg::cfg_type          cfg,
   input  logic                       cmd_valid,
   input  bdlp_pkg::cmd_type          cmd,
   output logic                       cmd_take,
   output bdlp_pkg::push_type         push,
   output logic                       pop,
   input  bdlp_pkg::event_type        rd_data,
   input  bdlp_pkg::evq_status_type   status,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_event_valid,
   output logic [1:0]                 rsp_event_kind,
   output logic [2:0]                 rsp_button_index,
   output logic [31:0]                rsp_event_time,
   output logic [3:0]                 rsp_queue_count
);
   import bdlp_pkg::*;

   localparam int BTN_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam logic [BTN_W-1:0] BTN_LAST = BTN_W'(BUTTON_COUNT - 1);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_VISIT    = 5'b00010,
      ST_EXTRA    = 5'b00100,
      ST_DONE     = 5'b01000,
      ST_POP_READ = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [BTN_W-1:0]       btn_ff, btn_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [LEVELS_W-1:0]    levels_ff, levels_in;

   // per-button state
   logic                   prev_ff [BUTTON_COUNT];
   logic                   deb_ff  [BUTTON_COUNT];
   logic                   pr_ff   [BUTTON_COUNT];
   logic                   lg_ff   [BUTTON_COUNT];
   logic [TIME_W-1:0]      ct_ff   [BUTTON_COUNT];
   logic [TIME_W-1:0]      rt_ff   [BUTTON_COUNT];

   logic                   prev_in, deb_in, pr_in, lg_in;
   logic [TIME_W-1:0]      ct_in, rt_in;

   logic                   rsp_valid_ff;
   logic                   rsp_event_valid_ff;
   kind_type               rsp_kind_ff;
   logic [BTN_IDX_W-1:0]   rsp_button_ff;
   logic [TIME_W-1:0]      rsp_time_ff;
   logic [QCOUNT_W-1:0]    rsp_count_ff;

   logic [BTN_W+2:0]       btn_ext;
   logic                   level;
   logic                   start;
   logic                   deb1;
   logic [TIME_W-1:0]      d_ct;
   logic [TIME_W-1:0]      d_rt;
   logic                   settle;
   logic                   down;
   logic                   press_now;
   logic                   short_ev, long_ev, rep_ev;
   logic                   rt_is_now;
   logic                   last_btn;

   assign btn_ext  = {3'b000, btn_ff};
   assign last_btn = (btn_ff == BTN_LAST);
   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid && !rsp_valid_ff;
   assign pop      = cmd_take && (cmd.op == OP_POP) && !status.empty;

   // one button visit
   always_comb begin
      level = 1'b1;
      if ((btn_ext >> 3) == '0) begin
         level = levels_ff[btn_ext[2:0]];
      end
      start   = !deb_ff[btn_ff] && (level != prev_ff[btn_ff]);
      deb1    = deb_ff[btn_ff] || start;
      ct_in   = start ? time_ff : ct_ff[btn_ff];
      prev_in = level;
      d_ct    = time_ff - ct_in;
      d_rt    = time_ff - rt_ff[btn_ff];
      settle  = deb1 && (d_ct >= {16'h0000, cfg.debounce_time});
      down    = !level;

      pr_in     = pr_ff[btn_ff];
      lg_in     = lg_ff[btn_ff];
      rt_in     = rt_ff[btn_ff];
      deb_in    = deb1;
      short_ev  = 1'b0;
      press_now = 1'b0;
      if (settle) begin
         if (down != pr_ff[btn_ff]) begin
            pr_in = down;
            if (down) begin
               lg_in     = 1'b0;
               rt_in     = time_ff;
               press_now = 1'b1;
            end else begin
               short_ev = !lg_ff[btn_ff];
               lg_in    = 1'b0;
            end
         end
         deb_in = 1'b0;
      end

      long_ev = pr_in && !deb_in && !lg_in && (d_ct >= {16'h0000, cfg.long_press_time});
      if (long_ev) begin
         lg_in = 1'b1;
         rt_in = time_ff;
      end
      rt_is_now = long_ev || press_now;
      rep_ev = pr_in && !deb_in && lg_in &&
               ((rt_is_now ? '0 : d_rt) >= {16'h0000, cfg.repeat_interval});
      if (rep_ev) begin
         rt_in = time_ff;
      end
   end

   always_comb begin
      push.valid     = 1'b0;
      push.ev.kind   = KIND_REPEAT;
      push.ev.button = btn_ext[2:0];
      push.ev.stamp  = time_ff;
      case (state_ff)
         ST_VISIT: begin
            push.valid = short_ev || long_ev || rep_ev;
            if (short_ev) begin
               push.ev.kind = KIND_SHORT;
            end else if (long_ev) begin
               push.ev.kind = KIND_LONG;
            end
         end
         ST_EXTRA: begin
            push.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      btn_in    = btn_ff;
      time_in   = time_ff;
      levels_in = levels_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               if (cmd.op == OP_TICK) begin
                  time_in   = time_ff + TIME_W'(1);
                  levels_in = cmd.levels;
                  btn_in    = '0;
                  state_in  = ST_VISIT;
               end else if (status.empty) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_POP_READ;
               end
            end
         end
         ST_VISIT: begin
            // long start and repeat on the same tick need a second write
            if (long_ev && rep_ev) begin
               state_in = ST_EXTRA;
            end else if (last_btn) begin
               state_in = ST_DONE;
            end else begin
               btn_in = btn_ff + BTN_W'(1);
            end
         end
         ST_EXTRA: begin
            if (last_btn) begin
               state_in = ST_DONE;
            end else begin
               btn_in   = btn_ff + BTN_W'(1);
               state_in = ST_VISIT;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         ST_POP_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         btn_ff   <= '0;
         time_ff  <= '0;
      end else begin
         state_ff <= state_in;
         btn_ff   <= btn_in;
         time_ff  <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            prev_ff[i] <= 1'b1;
            deb_ff[i]  <= 1'b0;
            pr_ff[i]   <= 1'b0;
            lg_ff[i]   <= 1'b0;
            ct_ff[i]   <= '0;
            rt_ff[i]   <= '0;
         end
      end else if (state_ff == ST_VISIT) begin
         prev_ff[btn_ff] <= prev_in;
         deb_ff[btn_ff]  <= deb_in;
         pr_ff[btn_ff]   <= pr_in;
         lg_ff[btn_ff]   <= lg_in;
         ct_ff[btn_ff]   <= ct_in;
         rt_ff[btn_ff]   <= rt_in;
      end
   end

   // result register; loaded only while empty
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff inside {ST_DONE, ST_POP_READ}) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         rsp_event_valid_ff <= 1'b0;
         rsp_kind_ff        <= KIND_SHORT;
         rsp_button_ff      <= '0;
         rsp_time_ff        <= '0;
         rsp_count_ff       <= status.count;
      end else if (state_ff == ST_POP_READ) begin
         rsp_event_valid_ff <= 1'b1;
         rsp_kind_ff        <= rd_data.kind;
         rsp_button_ff      <= rd_data.button;
         rsp_time_ff        <= rd_data.stamp;
         rsp_count_ff       <= status.count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_valid  = rsp_event_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_button_index = rsp_button_ff;
   assign rsp_event_time   = rsp_time_ff;
   assign rsp_queue_count  = rsp_count_ff;

endmodule

// ----- rtl/button_debounce_long_press_events_core.sv -----
// Debouncer for up to BUTTON_COUNT active-low buttons with short-press, long-press-start and
// long-press-repeat events kept in a ring queue of QUEUE_DEPTH-1 events (new events are
// dropped when it is full). Each item first passes through a two-item command queue;
// the engine then works on it. A tick item (operation 0) advances the millisecond count and
// visits the buttons one per cycle, with an extra step for each button that makes both
// a long-press start and a repeat on that tick, since the event memory has a single
// write port. A pop item goes through the registered memory read or, on an empty queue,
// through the done state. The engine takes the next item only once the result has been
// accepted; the command queue keeps taking items while a result waits on rsp_stall.
// Registers written over the csr_ port at index 0 (debounce time), 1 (long press time)
// and 2 (repeat interval); other indexes are ignored.
module button_debounce_long_press_events_core #(
   parameter int BUTTON_COUNT = 8,
   parameter int QUEUE_DEPTH  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_operation,
   input  logic [7:0]   req_levels,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_event_valid,
   output logic [1:0]   rsp_event_kind,
   output logic [2:0]   rsp_button_index,
   output logic [31:0]  rsp_event_time,
   output logic [3:0]   rsp_queue_count,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import bdlp_pkg::*;

   cfg_type          cfg_ff;
   logic             cmd_valid;
   cmd_type          cmd;
   logic             cmd_take;
   push_type         push;
   logic             pop;
   event_type        rd_data;
   evq_status_type   status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= 16'd50;
         cfg_ff.long_press_time <= 16'd1000;
         cfg_ff.repeat_interval <= 16'd200;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEBOUNCE_TIME:   cfg_ff.debounce_time   <= csr_data;
            CSR_LONG_PRESS_TIME: cfg_ff.long_press_time <= csr_data;
            CSR_REPEAT_INTERVAL: cfg_ff.repeat_interval <= csr_data;
            default: begin
            end
         endcase
      end
   end

   bdlp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_levels    (req_levels),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   bdlp_evq #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_evq (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .rd_data (rd_data),
      .status  (status)
   );

   bdlp_engine #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_take         (cmd_take),
      .push             (push),
      .pop              (pop),
      .rd_data          (rd_data),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_valid  (rsp_event_valid),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_button_index (rsp_button_index),
      .rsp_event_time   (rsp_event_time),
      .rsp_queue_count  (rsp_queue_count)
   );

endmodule
